// File: rtl/svpwm_pkg.sv
// Shared types and fixed-point constants for the space-vector PWM duty calculator.
// Used by every module of the block except svpwm_checker; depends on nothing else.
`default_nettype none

package svpwm_pkg;

	// Default sample width of the alpha/beta inputs and duty outputs.
	localparam int SAMPLE_WIDTH_DEF = 16;

	// Internal widths: Q30 operands, full product, active times, Q31 duties.
	localparam int QW = 32;
	localparam int PW = 62;
	localparam int TW = 34;
	localparam int DW = 36;

	// 1/sqrt(3) in Q30; 2/sqrt(3) is exactly twice this value.
	localparam logic signed [QW-1:0] INV_SQRT3_Q30 = 32'sd619925131;

	// Rounding offsets for shifts by 30 and 29, ties away from zero.
	localparam logic signed [PW-1:0] RND30   = 62'sd536870912;
	localparam logic signed [PW-1:0] RND30_N = 62'sd536870911;
	localparam logic signed [PW-1:0] RND29   = 62'sd268435456;
	localparam logic signed [PW-1:0] RND29_N = 62'sd268435455;

	// One in Q30 (start of the duty chain) and one in Q31 (duty limit).
	localparam logic signed [DW-1:0] ONE_Q30 = 36'sd1073741824;
	localparam logic signed [DW-1:0] ONE_Q31 = 36'sd2147483648;

	// Sector codes; zero marks an invalid result.
	typedef enum logic [2:0] {
		SECTOR_NONE = 3'd0,
		SECTOR_1    = 3'd1,
		SECTOR_2    = 3'd2,
		SECTOR_3    = 3'd3,
		SECTOR_4    = 3'd4,
		SECTOR_5    = 3'd5,
		SECTOR_6    = 3'd6
	} sector_t;

	// Front end result: Q30 alpha, rounded beta products, sign of beta.
	typedef struct packed {
		logic signed [QW-1:0] a;
		logic signed [QW-1:0] kb;
		logic signed [QW-1:0] k2b;
		logic                 b_neg;
	} front_t;

	// Sector stage result: sector, first duty and the two ordered addends.
	typedef struct packed {
		sector_t              sector;
		logic signed [DW-1:0] p0;
		logic signed [TW-1:0] d1;
		logic signed [TW-1:0] d2;
	} sect_t;

endpackage

`default_nettype wire

// File: rtl/svpwm_duty_calculator.sv
// Space-vector PWM duty calculator, center aligned, seven register stages.
// A request accepted at a clock edge passes stages 1 to 7 in order and shows done
// with its result once it reaches the output registers of stage 7.
// One request per cycle is taken indefinitely; busy stays low, the receiver cannot stall.
// The asynchronous reset clears all stage valid bits; requests in flight are dropped.
// Depends on svpwm_pkg, svpwm_front, svpwm_sector and svpwm_duty.
`default_nettype none

module svpwm_duty_calculator #(
	parameter int SAMPLE_WIDTH = svpwm_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic signed [SAMPLE_WIDTH-1:0] alpha_voltage,
	input  wire logic signed [SAMPLE_WIDTH-1:0] beta_voltage,
	output logic                                done,
	output logic [SAMPLE_WIDTH-1:0]             duty_phase_a,
	output logic [SAMPLE_WIDTH-1:0]             duty_phase_b,
	output logic [SAMPLE_WIDTH-1:0]             duty_phase_c,
	output logic [2:0]                          sector_number,
	output logic                                result_valid
);

	logic              front_vld;
	svpwm_pkg::front_t front_data;
	logic              sect_vld;
	svpwm_pkg::sect_t  sect_data;

	// The pipeline never holds a request back.
	assign busy = 1'b0;

	// Conversion, multiplication and rounding.
	svpwm_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start),
		.alpha_in (alpha_voltage),
		.beta_in  (beta_voltage),
		.out_vld  (front_vld),
		.out_data (front_data)
	);

	// Sector and active times.
	svpwm_sector u_sector (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (front_vld),
		.in_data  (front_data),
		.out_vld  (sect_vld),
		.out_data (sect_data)
	);

	// Phase duties and output registers.
	svpwm_duty #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_duty (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (sect_vld),
		.in_data (sect_data),
		.out_vld (done),
		.duty_a  (duty_phase_a),
		.duty_b  (duty_phase_b),
		.duty_c  (duty_phase_c),
		.sector  (sector_number),
		.ok      (result_valid)
	);

endmodule

`default_nettype wire

// File: rtl/svpwm_front.sv
// Front end: input conversion to Q30, beta times 1/sqrt(3), product rounding.
// Three pipeline stages; uses svpwm_pkg.
`default_nettype none

module svpwm_front #(
	parameter int SAMPLE_WIDTH = svpwm_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_vld,
	input  wire logic signed [SAMPLE_WIDTH-1:0] alpha_in,
	input  wire logic signed [SAMPLE_WIDTH-1:0] beta_in,
	output logic                                out_vld,
	output svpwm_pkg::front_t                   out_data
);

	localparam int SH = (SAMPLE_WIDTH <= 31) ? 31 - SAMPLE_WIDTH : 0;

	logic signed [32:0]                   ext_a;
	logic signed [32:0]                   ext_b;
	logic signed [svpwm_pkg::QW-1:0]      a_conv;
	logic signed [svpwm_pkg::QW-1:0]      b_conv;
	logic                                 vld_s1;
	logic signed [svpwm_pkg::QW-1:0]      a_s1;
	logic signed [svpwm_pkg::QW-1:0]      b_s1;
	logic signed [2*svpwm_pkg::QW-1:0]    prod_full;
	logic                                 vld_s2;
	logic signed [svpwm_pkg::PW-1:0]      prod_s2;
	logic signed [svpwm_pkg::QW-1:0]      a_s2;
	logic                                 bneg_s2;
	logic signed [svpwm_pkg::PW-1:0]      kb_sum;
	logic signed [svpwm_pkg::PW-1:0]      k2b_sum;
	logic                                 vld_s3;
	svpwm_pkg::front_t                    data_s3;

	// Bring both samples to Q30; the widest sample width drops one bit, rounded.
	always_comb begin
		ext_a = 33'(alpha_in);
		ext_b = 33'(beta_in);
		if (SAMPLE_WIDTH <= 31) begin
			a_conv = svpwm_pkg::QW'(ext_a <<< SH);
			b_conv = svpwm_pkg::QW'(ext_b <<< SH);
		end else begin
			a_conv = svpwm_pkg::QW'((ext_a + $signed({32'd0, ~ext_a[32]})) >>> 1);
			b_conv = svpwm_pkg::QW'((ext_b + $signed({32'd0, ~ext_b[32]})) >>> 1);
		end
	end

	// Stage 1 captures the converted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= a_conv;
		b_s1 <= b_conv;
	end

	// Stage 2 holds the single multiplication beta * 1/sqrt(3).
	assign prod_full = b_s1 * svpwm_pkg::INV_SQRT3_Q30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_full[svpwm_pkg::PW-1:0];
		a_s2    <= a_s1;
		bneg_s2 <= b_s1[svpwm_pkg::QW-1];
	end

	// Round the product to Q30 for kb and to Q31 for k2b, ties away from zero.
	always_comb begin
		kb_sum  = prod_s2 + (prod_s2[svpwm_pkg::PW-1] ? svpwm_pkg::RND30_N : svpwm_pkg::RND30);
		k2b_sum = prod_s2 + (prod_s2[svpwm_pkg::PW-1] ? svpwm_pkg::RND29_N : svpwm_pkg::RND29);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		data_s3.a     <= a_s2;
		data_s3.kb    <= svpwm_pkg::QW'(kb_sum >>> 30);
		data_s3.k2b   <= svpwm_pkg::QW'(k2b_sum >>> 29);
		data_s3.b_neg <= bneg_s2;
	end

	assign out_vld  = vld_s3;
	assign out_data = data_s3;

endmodule

`default_nettype wire

// File: rtl/svpwm_sector.sv
// Sector selection, active-vector times and the first duty of the chain.
// Two pipeline stages; uses svpwm_pkg.
`default_nettype none

module svpwm_sector (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_vld,
	input  svpwm_pkg::front_t      in_data,
	output logic                   out_vld,
	output svpwm_pkg::sect_t       out_data
);

	logic signed [svpwm_pkg::TW-1:0] ax;
	logic signed [svpwm_pkg::TW-1:0] kbx;
	logic signed [svpwm_pkg::TW-1:0] k2bx;
	logic                            a_neg;
	svpwm_pkg::sector_t              sec;
	logic signed [svpwm_pkg::TW-1:0] d1;
	logic signed [svpwm_pkg::TW-1:0] d2;
	logic                            vld_s4;
	svpwm_pkg::sector_t              sec_s4;
	logic signed [svpwm_pkg::TW-1:0] d1_s4;
	logic signed [svpwm_pkg::TW-1:0] d2_s4;
	logic                            vld_s5;
	svpwm_pkg::sect_t                data_s5;

	// Pick the sector from the quadrant and the alpha against beta/sqrt(3) test.
	always_comb begin
		ax    = svpwm_pkg::TW'(in_data.a);
		kbx   = svpwm_pkg::TW'(in_data.kb);
		k2bx  = svpwm_pkg::TW'(in_data.k2b);
		a_neg = in_data.a[svpwm_pkg::QW-1];
		if (!in_data.b_neg) begin
			if (!a_neg) begin
				sec = (kbx > ax) ? svpwm_pkg::SECTOR_2 : svpwm_pkg::SECTOR_1;
			end else begin
				sec = (-kbx > ax) ? svpwm_pkg::SECTOR_3 : svpwm_pkg::SECTOR_2;
			end
		end else begin
			if (!a_neg) begin
				sec = (-kbx > ax) ? svpwm_pkg::SECTOR_5 : svpwm_pkg::SECTOR_6;
			end else begin
				sec = (kbx > ax) ? svpwm_pkg::SECTOR_4 : svpwm_pkg::SECTOR_5;
			end
		end
	end

	// Active times, ordered as the duty chain adds them in each sector.
	always_comb begin
		unique case (sec)
			svpwm_pkg::SECTOR_1: begin
				d1 = ax - kbx;
				d2 = k2bx;
			end
			svpwm_pkg::SECTOR_2: begin
				d1 = kbx - ax;
				d2 = ax + kbx;
			end
			svpwm_pkg::SECTOR_3: begin
				d1 = k2bx;
				d2 = -ax - kbx;
			end
			svpwm_pkg::SECTOR_4: begin
				d1 = -k2bx;
				d2 = kbx - ax;
			end
			svpwm_pkg::SECTOR_5: begin
				d1 = -ax - kbx;
				d2 = ax - kbx;
			end
			svpwm_pkg::SECTOR_6: begin
				d1 = ax + kbx;
				d2 = -k2bx;
			end
			default: begin
				d1 = '0;
				d2 = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		sec_s4 <= sec;
		d1_s4  <= d1;
		d2_s4  <= d2;
	end

	// The first duty takes half the zero-vector time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		data_s5.sector <= sec_s4;
		data_s5.p0     <= svpwm_pkg::ONE_Q30 - svpwm_pkg::DW'(d1_s4)
			- svpwm_pkg::DW'(d2_s4);
		data_s5.d1     <= d1_s4;
		data_s5.d2     <= d2_s4;
	end

	assign out_vld  = vld_s5;
	assign out_data = data_s5;

endmodule

`default_nettype wire

// File: rtl/svpwm_duty.sv
// Remaining duties, phase assignment, range check and output rounding.
// Two pipeline stages ending in the output registers; uses svpwm_pkg.
`default_nettype none

module svpwm_duty #(
	parameter int SAMPLE_WIDTH = svpwm_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_vld,
	input  svpwm_pkg::sect_t             in_data,
	output logic                         out_vld,
	output logic [SAMPLE_WIDTH-1:0]      duty_a,
	output logic [SAMPLE_WIDTH-1:0]      duty_b,
	output logic [SAMPLE_WIDTH-1:0]      duty_c,
	output logic [2:0]                   sector,
	output logic                         ok
);

	localparam int OS   = 32 - SAMPLE_WIDTH;
	localparam int OSM1 = (OS > 0) ? OS - 1 : 0;
	localparam logic signed [svpwm_pkg::DW-1:0] OHALF =
		(OS > 0) ? (svpwm_pkg::DW'(1) <<< OSM1) : '0;

	logic signed [svpwm_pkg::DW-1:0] p1;
	logic signed [svpwm_pkg::DW-1:0] p2;
	logic signed [svpwm_pkg::DW-1:0] pa;
	logic signed [svpwm_pkg::DW-1:0] pb;
	logic signed [svpwm_pkg::DW-1:0] pc;
	logic                            vld_s6;
	svpwm_pkg::sector_t              sec_s6;
	logic signed [svpwm_pkg::DW-1:0] pa_s6;
	logic signed [svpwm_pkg::DW-1:0] pb_s6;
	logic signed [svpwm_pkg::DW-1:0] pc_s6;
	logic                            in_range;
	logic                            vld_s7;
	logic [SAMPLE_WIDTH-1:0]         duty_a_s7;
	logic [SAMPLE_WIDTH-1:0]         duty_b_s7;
	logic [SAMPLE_WIDTH-1:0]         duty_c_s7;
	svpwm_pkg::sector_t              sec_s7;
	logic                            ok_s7;

	// Each later duty adds twice an active time to the one before it.
	always_comb begin
		p1 = in_data.p0 + (svpwm_pkg::DW'(in_data.d1) <<< 1);
		p2 = in_data.p0 + ((svpwm_pkg::DW'(in_data.d1) + svpwm_pkg::DW'(in_data.d2)) <<< 1);
	end

	// Route the three chain values to the phases of this sector.
	always_comb begin
		unique case (in_data.sector)
			svpwm_pkg::SECTOR_1: begin
				pa = in_data.p0; pb = p1;         pc = p2;
			end
			svpwm_pkg::SECTOR_2: begin
				pb = in_data.p0; pa = p1;         pc = p2;
			end
			svpwm_pkg::SECTOR_3: begin
				pb = in_data.p0; pc = p1;         pa = p2;
			end
			svpwm_pkg::SECTOR_4: begin
				pc = in_data.p0; pb = p1;         pa = p2;
			end
			svpwm_pkg::SECTOR_5: begin
				pc = in_data.p0; pa = p1;         pb = p2;
			end
			svpwm_pkg::SECTOR_6: begin
				pa = in_data.p0; pc = p1;         pb = p2;
			end
			default: begin
				pa = '0;         pb = '0;         pc = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		sec_s6 <= in_data.sector;
		pa_s6  <= pa;
		pb_s6  <= pb;
		pc_s6  <= pc;
	end

	// All duties must lie within zero and one, or the whole result is cleared.
	assign in_range = !pa_s6[svpwm_pkg::DW-1] && (pa_s6 <= svpwm_pkg::ONE_Q31)
		&& !pb_s6[svpwm_pkg::DW-1] && (pb_s6 <= svpwm_pkg::ONE_Q31)
		&& !pc_s6[svpwm_pkg::DW-1] && (pc_s6 <= svpwm_pkg::ONE_Q31);

	// Output registers: round Q31 to the nearest value in the sample format.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		ok_s7 <= in_range;
		if (in_range) begin
			duty_a_s7 <= SAMPLE_WIDTH'((pa_s6 + OHALF) >>> OS);
			duty_b_s7 <= SAMPLE_WIDTH'((pb_s6 + OHALF) >>> OS);
			duty_c_s7 <= SAMPLE_WIDTH'((pc_s6 + OHALF) >>> OS);
			sec_s7    <= sec_s6;
		end else begin
			duty_a_s7 <= '0;
			duty_b_s7 <= '0;
			duty_c_s7 <= '0;
			sec_s7    <= svpwm_pkg::SECTOR_NONE;
		end
	end

	assign out_vld = vld_s7;
	assign duty_a  = duty_a_s7;
	assign duty_b  = duty_b_s7;
	assign duty_c  = duty_c_s7;
	assign sector  = sec_s7;
	assign ok      = ok_s7;

endmodule

`default_nettype wire

// File: rtl/svpwm_checker.sv
// Port-level checks for the duty calculator, attached to the top level by bind.
// Uses only the top-level ports; no package dependency.
`default_nettype none

module svpwm_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    start,
	input wire logic                    busy,
	input wire logic [SAMPLE_WIDTH-1:0] alpha_voltage,
	input wire logic [SAMPLE_WIDTH-1:0] beta_voltage,
	input wire logic                    done,
	input wire logic [SAMPLE_WIDTH-1:0] duty_phase_a,
	input wire logic [SAMPLE_WIDTH-1:0] duty_phase_b,
	input wire logic [SAMPLE_WIDTH-1:0] duty_phase_c,
	input wire logic [2:0]              sector_number,
	input wire logic                    result_valid
);

	localparam logic [SAMPLE_WIDTH-1:0] FULL = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	// Every accepted request produces exactly one result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##7 done)
		else $error("accepted request produced no result");

	// No result appears without a matching earlier request.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 7))
		else $error("result without a matching request");

	// An invalid result carries all-zero duties and sector.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result_valid |-> duty_phase_a == '0 && duty_phase_b == '0
			&& duty_phase_c == '0 && sector_number == 3'd0)
		else $error("invalid result not cleared");

	// A valid result has a real sector and duties no larger than one.
	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && result_valid |-> sector_number != 3'd0 && sector_number != 3'd7
			&& duty_phase_a <= FULL && duty_phase_b <= FULL && duty_phase_c <= FULL)
		else $error("valid result out of range");

endmodule

bind svpwm_duty_calculator svpwm_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_svpwm_checker (.*);

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the space-vector PWM duty calculator (svpwm_duty_calculator).
// Drives alpha/beta requests and checks each duty result against a built-in fixed-point model.
// Depends on svpwm_pkg and the RTL of the block; reads no files.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = 16;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 12;

	// Q30 constants of the scheme: 1/sqrt(3) and 2/sqrt(3).
	localparam longint INV_SQRT3 = 64'sd619925131;
	localparam longint TWO_INV_SQRT3 = 64'sd1239850262;
	localparam longint ONE_Q30 = 64'sd1 <<< 30;
	localparam longint ONE_Q31 = 64'sd1 <<< 31;

	typedef struct {
		logic [SW-1:0]      duty_a;
		logic [SW-1:0]      duty_b;
		logic [SW-1:0]      duty_c;
		svpwm_pkg::sector_t sector;
		logic               ok;
	} duty_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [SW-1:0] alpha_voltage;
	logic signed [SW-1:0] beta_voltage;
	logic                 done;
	logic [SW-1:0]        duty_phase_a;
	logic [SW-1:0]        duty_phase_b;
	logic [SW-1:0]        duty_phase_c;
	logic [2:0]           sector_number;
	logic                 result_valid;

	duty_result_t expected_duties[$];
	int           error_count;
	int           request_count;
	int           result_count;
	int           overmod_count;
	int           sector_hits[0:6];
	int           stall_cycles;
	bit           gaps_on;

	svpwm_duty_calculator #(
		.SAMPLE_WIDTH(SW)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.alpha_voltage(alpha_voltage),
		.beta_voltage (beta_voltage),
		.done         (done),
		.duty_phase_a (duty_phase_a),
		.duty_phase_b (duty_phase_b),
		.duty_phase_c (duty_phase_c),
		.sector_number(sector_number),
		.result_valid (result_valid)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Round a signed value right by s bits, ties away from zero.
	function automatic longint round_down_by(longint v, int unsigned s);
		longint half;
		half = 64'sd1 <<< (s - 1);
		if (v >= 0) begin
			return (v + half) >>> s;
		end
		return -((-v + half) >>> s);
	endfunction

	// Expected duties and sector for one alpha/beta vector.
	function automatic duty_result_t compute_duties(logic signed [SW-1:0] al,
			logic signed [SW-1:0] be);
		longint             a;
		longint             b;
		longint             kb;
		longint             k2b;
		longint             tx;
		longint             ty;
		longint             pa;
		longint             pb;
		longint             pc;
		svpwm_pkg::sector_t sec;
		duty_result_t       r;
		a = longint'(al) <<< (31 - SW);
		b = longint'(be) <<< (31 - SW);
		kb = round_down_by(INV_SQRT3 * b, 30);
		k2b = round_down_by(TWO_INV_SQRT3 * b, 30);

		// Sector from the quadrant and the alpha versus beta/sqrt(3) test.
		if (b >= 0) begin
			if (a >= 0) sec = (kb > a) ? svpwm_pkg::SECTOR_2 : svpwm_pkg::SECTOR_1;
			else sec = (-kb > a) ? svpwm_pkg::SECTOR_3 : svpwm_pkg::SECTOR_2;
		end else begin
			if (a >= 0) sec = (-kb > a) ? svpwm_pkg::SECTOR_5 : svpwm_pkg::SECTOR_6;
			else sec = (kb > a) ? svpwm_pkg::SECTOR_4 : svpwm_pkg::SECTOR_5;
		end

		// Active times and duties; the zero-vector time is split at both ends.
		case (sec)
			svpwm_pkg::SECTOR_1: begin
				tx = a - kb; ty = k2b;
				pa = ONE_Q30 - tx - ty; pb = pa + 2 * tx; pc = pb + 2 * ty;
			end
			svpwm_pkg::SECTOR_2: begin
				tx = a + kb; ty = -a + kb;
				pb = ONE_Q30 - tx - ty; pa = pb + 2 * ty; pc = pa + 2 * tx;
			end
			svpwm_pkg::SECTOR_3: begin
				tx = k2b; ty = -a - kb;
				pb = ONE_Q30 - tx - ty; pc = pb + 2 * tx; pa = pc + 2 * ty;
			end
			svpwm_pkg::SECTOR_4: begin
				tx = -a + kb; ty = -k2b;
				pc = ONE_Q30 - tx - ty; pb = pc + 2 * ty; pa = pb + 2 * tx;
			end
			svpwm_pkg::SECTOR_5: begin
				tx = -a - kb; ty = a - kb;
				pc = ONE_Q30 - tx - ty; pa = pc + 2 * tx; pb = pa + 2 * ty;
			end
			default: begin
				tx = -k2b; ty = a + kb;
				pa = ONE_Q30 - tx - ty; pc = pa + 2 * ty; pb = pc + 2 * tx;
			end
		endcase

		// Overmodulation clears the whole result.
		if (pa < 0 || pa > ONE_Q31 || pb < 0 || pb > ONE_Q31 || pc < 0 || pc > ONE_Q31) begin
			r.duty_a = '0;
			r.duty_b = '0;
			r.duty_c = '0;
			r.sector = svpwm_pkg::SECTOR_NONE;
			r.ok = 1'b0;
		end else begin
			r.duty_a = SW'(round_down_by(pa, 32 - SW));
			r.duty_b = SW'(round_down_by(pb, 32 - SW));
			r.duty_c = SW'(round_down_by(pc, 32 - SW));
			r.sector = sec;
			r.ok = 1'b1;
		end
		return r;
	endfunction

	// One line per mismatch, and a running count.
	task automatic report_mismatch(string what, longint got, longint want);
		error_count++;
		$display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Request capture, result checking and the stall watchdog.
	always @(posedge clk) begin
		duty_result_t e;
		if (arst_n) begin
			if (done) begin
				result_count++;
				if (expected_duties.size() == 0) begin
					report_mismatch("result with no request pending", result_count, 0);
				end else begin
					e = expected_duties.pop_front();
					if (duty_phase_a !== e.duty_a) report_mismatch("duty_phase_a", duty_phase_a, e.duty_a);
					if (duty_phase_b !== e.duty_b) report_mismatch("duty_phase_b", duty_phase_b, e.duty_b);
					if (duty_phase_c !== e.duty_c) report_mismatch("duty_phase_c", duty_phase_c, e.duty_c);
					if (sector_number !== e.sector) report_mismatch("sector_number", sector_number, e.sector);
					if (result_valid !== e.ok) report_mismatch("result_valid", result_valid, e.ok);
					if (e.ok) sector_hits[e.sector]++;
					else overmod_count++;
				end
			end
			if (start && !busy) begin
				expected_duties.push_back(compute_duties(alpha_voltage, beta_voltage));
				request_count++;
			end
			if (done || (start && !busy)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Timeout: no request or result for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Send one request; start stays high between back-to-back requests.
	task automatic send_vector(int al, int be);
		while (gaps_on && $urandom_range(99) < 30) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		alpha_voltage <= SW'(al);
		beta_voltage <= SW'(be);
		do @(posedge clk); while (busy);
	endtask

	function automatic int clamp_sample(int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Extremes, zero vector, one vector per sector, boundaries and the hexagon edge.
	task automatic test_directed();
		send_vector(0, 0);
		send_vector(32767, 0);
		send_vector(-32768, 0);
		send_vector(0, 32767);
		send_vector(0, -32768);
		send_vector(-32768, -32768);
		send_vector(32767, 32767);
		send_vector(32767, -32768);
		send_vector(-32768, 32767);
		send_vector(14189, 8192);
		send_vector(0, 16384);
		send_vector(-14189, 8192);
		send_vector(-14189, -8192);
		send_vector(0, -16384);
		send_vector(14189, -8192);
		send_vector(9459, 16384);
		send_vector(9460, 16384);
		send_vector(-9459, 16384);
		send_vector(-9460, -16384);
		send_vector(9459, -16384);
		send_vector(16384, 28378);
		send_vector(16384, 28400);
		send_vector(-1, -1);
		send_vector(1, -1);
	endtask

	// Vectors mostly inside the linear region, first without any gaps.
	task automatic test_linear_region(int count);
		for (int i = 0; i < count; i++) begin
			gaps_on = (i >= count / 2);
			send_vector($urandom_range(56000) - 28000, $urandom_range(56000) - 28000);
		end
		gaps_on = 1'b1;
	endtask

	// Vectors on or next to the sector boundaries alpha = +-beta/sqrt(3), some with beta then scaled down.
	task automatic test_sector_edges(int count);
		int be;
		int al;
		for (int i = 0; i < count; i++) begin
			be = $urandom_range(65535) - 32768;
			al = (be * 18919) >>> 15;
			if ($urandom_range(1)) al = -al;
			al = clamp_sample(al + $urandom_range(4) - 2);
			if ($urandom_range(3) == 0) be = be >>> $urandom_range(8);
			send_vector(al, be);
		end
	endtask

	// Full-scale vectors, some of them overmodulated.
	task automatic test_full_scale(int count);
		for (int i = 0; i < count; i++) begin
			send_vector($urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
		end
	endtask

	// Stimulus, drain and final verdict.
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		alpha_voltage = '0;
		beta_voltage = '0;
		error_count = 0;
		request_count = 0;
		result_count = 0;
		overmod_count = 0;
		stall_cycles = 0;
		gaps_on = 1'b1;
		for (int s = 0; s <= 6; s++) sector_hits[s] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_linear_region(700);
		test_sector_edges(400);
		test_full_scale(400);
		start <= 1'b0;

		while (expected_duties.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d requests, %0d results: %0d overmodulated, %0d mismatches.",
			request_count, result_count, overmod_count, error_count);
		$display("Valid results per sector 1..6: %0d %0d %0d %0d %0d %0d",
			sector_hits[1], sector_hits[2], sector_hits[3], sector_hits[4], sector_hits[5],
			sector_hits[6]);
		if (error_count == 0 && expected_duties.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/svpwm_pkg.sv
rtl/svpwm_front.sv
rtl/svpwm_sector.sv
rtl/svpwm_duty.sv
rtl/svpwm_duty_calculator.sv
rtl/svpwm_checker.sv
sim/tb.sv
